### rtl/midpoint_line_rasterizer_core_defines.svh
// Assertion macros used by the rasterizer core.
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlr assertion failed");

// Next-cycle implication, checked outside reset.
`define MLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlr assertion failed");

`endif

### rtl/mlr_pkg.sv
`default_nettype none

package mlr_pkg;

   localparam int PIXEL_BITS = 16;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [PIXEL_BITS-1:0] x_start;
      logic [PIXEL_BITS-1:0] y_start;
      logic [PIXEL_BITS-1:0] x_end;
      logic [PIXEL_BITS-1:0] y_end;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_x;
      logic [PIXEL_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/mlr_setup.sv
`default_nettype none

// Endpoint ordering and major-axis pick for a load word.
module mlr_setup #(
   parameter int COORD_BITS = 16
) (
   input  wire logic [COORD_BITS-1:0] x_a,
   input  wire logic [COORD_BITS-1:0] y_a,
   input  wire logic [COORD_BITS-1:0] x_b,
   input  wire logic [COORD_BITS-1:0] y_b,
   output logic      [COORD_BITS-1:0] start_x,
   output logic      [COORD_BITS-1:0] start_y,
   output logic      [COORD_BITS-1:0] major_delta,
   output logic      [COORD_BITS-1:0] minor_delta,
   output logic                       minor_negative,
   output logic                       y_is_major
);

   logic                  swap;
   logic [COORD_BITS-1:0] end_y;
   logic [COORD_BITS-1:0] abs_dx;
   logic [COORD_BITS-1:0] abs_dy;

   always_comb begin
      swap    = (x_a > x_b);
      start_x = swap ? x_b : x_a;
      start_y = swap ? y_b : y_a;
      end_y   = swap ? y_a : y_b;
      abs_dx  = swap ? (x_a - x_b) : (x_b - x_a);
      minor_negative = (end_y < start_y);
      abs_dy  = minor_negative ? (start_y - end_y) : (end_y - start_y);
      // diagonal ties go y-major
      y_is_major  = (abs_dy >= abs_dx);
      major_delta = y_is_major ? abs_dy : abs_dx;
      minor_delta = y_is_major ? abs_dx : abs_dy;
   end

endmodule

`default_nettype wire

### rtl/midpoint_line_rasterizer_core.sv
// Midpoint line rasterizer core.
// A step word's pixel is registered and appears on rsp in the cycle after it is accepted.
// Throughput: one word per cycle while rsp is not stalled; the decision add/compare is the only loop.
// A load word produces no pixel.
// Reset (synchronous, active high) clears all line state: no line is active.
`default_nettype none

`include "midpoint_line_rasterizer_core_defines.svh"

module midpoint_line_rasterizer_core
   import mlr_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_payload
);

   // decision lies in [-2*major, 2*minor]; three extra bits cover sign and x2
   localparam int DEC_BITS = COORD_BITS + 3;
   localparam int REM_BITS = COORD_BITS + 1;

   // Line state
   logic [COORD_BITS-1:0]      current_x_ff, current_x_in;
   logic [COORD_BITS-1:0]      current_y_ff, current_y_in;
   logic [COORD_BITS-1:0]      major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0]      minor_delta_ff, minor_delta_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic [REM_BITS-1:0]        remaining_ff, remaining_in;
   logic                       minor_negative_ff, minor_negative_in;
   logic                       y_is_major_ff, y_is_major_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_word_type               rsp_word_ff, rsp_word_in;

   // Setup results for a load word
   logic [COORD_BITS-1:0]      ld_x, ld_y, ld_major, ld_minor;
   logic                       ld_minor_neg, ld_y_major;

   logic                       req_fire;
   logic                       is_load;
   logic                       emit;
   logic                       step_minor;
   logic [COORD_BITS-1:0]      y_moved;
   logic [DEC_BITS-1:0]        minor_x2;
   logic [DEC_BITS-1:0]        major_x2;

   mlr_setup #(
      .COORD_BITS(COORD_BITS)
   ) u_setup (
      .x_a           (COORD_BITS'(req_payload.x_start)),
      .y_a           (COORD_BITS'(req_payload.y_start)),
      .x_b           (COORD_BITS'(req_payload.x_end)),
      .y_b           (COORD_BITS'(req_payload.y_end)),
      .start_x       (ld_x),
      .start_y       (ld_y),
      .major_delta   (ld_major),
      .minor_delta   (ld_minor),
      .minor_negative(ld_minor_neg),
      .y_is_major    (ld_y_major)
   );

   // Output stage takes a new pixel whenever it is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_load   = (req_payload.action == ACTION_LOAD);
   assign emit      = req_fire && (req_payload.action == ACTION_STEP) && (remaining_ff != '0);

   assign minor_x2   = DEC_BITS'({minor_delta_ff, 1'b0});
   assign major_x2   = DEC_BITS'({major_delta_ff, 1'b0});
   // zero keeps the minor coordinate
   assign step_minor = (decision_ff > 0);
   assign y_moved    = minor_negative_ff ? (current_y_ff - 1'b1) : (current_y_ff + 1'b1);

   always_comb begin
      current_x_in      = current_x_ff;
      current_y_in      = current_y_ff;
      major_delta_in    = major_delta_ff;
      minor_delta_in    = minor_delta_ff;
      decision_in       = decision_ff;
      remaining_in      = remaining_ff;
      minor_negative_in = minor_negative_ff;
      y_is_major_in     = y_is_major_ff;

      if (req_fire && is_load) begin
         current_x_in      = ld_x;
         current_y_in      = ld_y;
         major_delta_in    = ld_major;
         minor_delta_in    = ld_minor;
         minor_negative_in = ld_minor_neg;
         y_is_major_in     = ld_y_major;
         // 2*minor - major, midpoint scaled by two
         decision_in       = DEC_BITS'({ld_minor, 1'b0}) - DEC_BITS'(ld_major);
         remaining_in      = REM_BITS'(ld_major);
      end else if (emit) begin
         if (y_is_major_ff) begin
            current_y_in = y_moved;
            if (step_minor) begin
               current_x_in = current_x_ff + 1'b1;
            end
         end else begin
            current_x_in = current_x_ff + 1'b1;
            if (step_minor) begin
               current_y_in = y_moved;
            end
         end
         // result fits DEC_BITS, so modular arithmetic is exact
         decision_in  = decision_ff + minor_x2 - (step_minor ? major_x2 : '0);
         remaining_in = remaining_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.pixel_x    = PIXEL_BITS'(current_x_ff);
         rsp_word_in.pixel_y    = PIXEL_BITS'(current_y_ff);
         rsp_word_in.last_pixel = (remaining_ff == REM_BITS'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_x_ff      <= '0;
         current_y_ff      <= '0;
         major_delta_ff    <= '0;
         minor_delta_ff    <= '0;
         decision_ff       <= '0;
         remaining_ff      <= '0;
         minor_negative_ff <= 1'b0;
         y_is_major_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         current_x_ff      <= current_x_in;
         current_y_ff      <= current_y_in;
         major_delta_ff    <= major_delta_in;
         minor_delta_ff    <= minor_delta_in;
         decision_ff       <= decision_in;
         remaining_ff      <= remaining_in;
         minor_negative_ff <= minor_negative_in;
         y_is_major_ff     <= y_is_major_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

   // Checks

   // the last pixel ends the line
   `MLR_ASSERT_NEXT(a_last_ends_line, clock, reset, emit && (remaining_ff == REM_BITS'(1)), remaining_ff == '0)
   // a degenerate load leaves no active line
   `MLR_ASSERT_NEXT(a_point_line_idle, clock, reset, req_fire && is_load && (req_payload.x_start == req_payload.x_end) && (req_payload.y_start == req_payload.y_end), remaining_ff == '0)
   // decision stays inside [-2*major, 2*minor]
   `MLR_ASSERT_NOW(a_decision_bounds, clock, reset, 1'b1, (decision_ff <= $signed(minor_x2)) && (decision_ff >= -$signed(major_x2)))

endmodule

`default_nettype wire
